### hdl/fcfs_pkg.sv
// Shared types and constants for the first-come-first-served tick scheduler.
// Used by fcfs_ctrl, fcfs_dpath and fcfs_tick_scheduler; depends on nothing.
package fcfs_pkg;

    // Process table depth. A power of two, so FIFO pointers wrap on their own.
    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int TIME_W    = 16;
    localparam int TICK_W    = 17;
    localparam int ID_W      = 5;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_HFETCH,
        ST_HLOAD,
        ST_SCAN,
        ST_FIN
    } fcfs_state_t;

    typedef struct packed {
        logic load;
        logic tick_start;
        logic pop;
        logic head_fetch;
        logic head_load;
        logic scan;
        logic finish;
    } fcfs_cmd_t;

    typedef struct packed {
        logic pop_refill;
        logic scan_done;
        logic out_free;
    } fcfs_status_t;

endpackage

### hdl/fcfs_ctrl.sv
// Sequencing state machine of the tick scheduler.
// Depends on fcfs_pkg; drives fcfs_dpath through command and status structs.
module fcfs_ctrl
    import fcfs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_opcode,
    output logic         s_ready,
    input  fcfs_status_t status,
    output fcfs_cmd_t    cmd
);

    fcfs_state_t state_reg;
    fcfs_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_opcode == OP_TICK) ? ST_POP : ST_FIN;
                end
            end
            ST_POP: begin
                state_next = status.pop_refill ? ST_HFETCH : ST_SCAN;
            end
            ST_HFETCH: begin
                state_next = ST_HLOAD;
            end
            ST_HLOAD: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        cmd.load       = (state_reg == ST_IDLE) && s_valid && (s_opcode == OP_LOAD);
        cmd.tick_start = (state_reg == ST_IDLE) && s_valid && (s_opcode == OP_TICK);
        cmd.pop        = (state_reg == ST_POP);
        cmd.head_fetch = (state_reg == ST_HFETCH);
        cmd.head_load  = (state_reg == ST_HLOAD);
        cmd.scan       = (state_reg == ST_SCAN);
        cmd.finish     = (state_reg == ST_FIN) && status.out_free;
    end

endmodule

### hdl/fcfs_dpath.sv
// Datapath of the tick scheduler: process tables, ready FIFO, counters, result register.
// Depends on fcfs_pkg; commanded by fcfs_ctrl.
module fcfs_dpath
    import fcfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  fcfs_cmd_t         cmd,
    output fcfs_status_t      status,
    input  logic [TIME_W-1:0] s_arrival_time,
    input  logic [TIME_W-1:0] s_burst_time,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [ID_W-1:0]   m_running_id,
    output logic              m_finished_valid,
    output logic [ID_W-1:0]   m_finished_id,
    output logic [TICK_W-1:0] m_tick_now,
    output logic              m_all_done,
    output logic              m_load_rejected
);

    // Tables and FIFO storage; contents are meaningful only once written.
    logic [TIME_W-1:0] arrival_table [MAX_PROCS];
    logic [TIME_W-1:0] burst_table   [MAX_PROCS];
    logic [IDX_W-1:0]  ready_fifo    [MAX_PROCS];

    logic [TIME_W-1:0] arr_rdata_reg;
    logic [TIME_W-1:0] bur_rdata_reg;
    logic [IDX_W-1:0]  fifo_rdata_reg;
    logic [IDX_W-1:0]  bur_raddr;
    logic [IDX_W-1:0]  fifo_raddr;
    logic              tbl_we;
    logic              table_full;
    logic              push;

    logic [IDX_W-1:0]  head_reg,      head_next;
    logic [IDX_W-1:0]  tail_reg,      tail_next;
    logic [CNT_W-1:0]  fill_reg,      fill_next;
    logic [TIME_W-1:0] rem_reg,       rem_next;
    logic [CNT_W-1:0]  loaded_reg,    loaded_next;
    logic [CNT_W-1:0]  completed_reg, completed_next;
    logic [TICK_W-1:0] tick_reg,      tick_next;
    logic [CNT_W-1:0]  scan_cnt_reg,  scan_cnt_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]  chk_idx_reg,   chk_idx_next;
    logic              op_tick_reg,   op_tick_next;
    logic [IDX_W-1:0]  head_idx_reg,  head_idx_next;
    logic              fin_valid_reg, fin_valid_next;
    logic [ID_W-1:0]   fin_id_reg,    fin_id_next;
    logic              rejected_reg,  rejected_next;

    logic              m_valid_reg,     m_valid_next;
    logic [ID_W-1:0]   m_running_reg,   m_running_next;
    logic              m_fin_valid_reg, m_fin_valid_next;
    logic [ID_W-1:0]   m_fin_id_reg,    m_fin_id_next;
    logic [TICK_W-1:0] m_tick_reg,      m_tick_next;
    logic              m_all_done_reg,  m_all_done_next;
    logic              m_rejected_reg,  m_rejected_next;

    assign table_full = (loaded_reg >= CNT_W'(MAX_PROCS));
    assign tbl_we     = cmd.load && !table_full;
    assign bur_raddr  = cmd.head_fetch ? fifo_rdata_reg : scan_cnt_reg[IDX_W-1:0];
    assign fifo_raddr = head_reg + IDX_W'(1);
    assign push       = cmd.scan && chk_valid_reg
                        && ({1'b0, arr_rdata_reg} == tick_reg)
                        && (fill_reg < CNT_W'(MAX_PROCS));

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            arrival_table[loaded_reg[IDX_W-1:0]] <= s_arrival_time;
            burst_table[loaded_reg[IDX_W-1:0]]   <= s_burst_time;
        end
        arr_rdata_reg <= arrival_table[scan_cnt_reg[IDX_W-1:0]];
        bur_rdata_reg <= burst_table[bur_raddr];
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ready_fifo[tail_reg] <= chk_idx_reg;
        end
        fifo_rdata_reg <= ready_fifo[fifo_raddr];
    end

    always_comb begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        rem_next         = rem_reg;
        loaded_next      = loaded_reg;
        completed_next   = completed_reg;
        tick_next        = tick_reg;
        scan_cnt_next    = scan_cnt_reg;
        chk_valid_next   = chk_valid_reg;
        chk_idx_next     = chk_idx_reg;
        op_tick_next     = op_tick_reg;
        head_idx_next    = head_idx_reg;
        fin_valid_next   = fin_valid_reg;
        fin_id_next      = fin_id_reg;
        rejected_next    = rejected_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_running_next   = m_running_reg;
        m_fin_valid_next = m_fin_valid_reg;
        m_fin_id_next    = m_fin_id_reg;
        m_tick_next      = m_tick_reg;
        m_all_done_next  = m_all_done_reg;
        m_rejected_next  = m_rejected_reg;

        if (cmd.load) begin
            op_tick_next   = 1'b0;
            rejected_next  = table_full;
            fin_valid_next = 1'b0;
            fin_id_next    = '0;
            if (!table_full) begin
                loaded_next = loaded_reg + CNT_W'(1);
            end
        end

        if (cmd.tick_start) begin
            op_tick_next   = 1'b1;
            rejected_next  = 1'b0;
            fin_valid_next = 1'b0;
            fin_id_next    = '0;
            scan_cnt_next  = '0;
            chk_valid_next = 1'b0;
        end

        // Retire the head once its remaining burst has run down to zero.
        if (cmd.pop && (fill_reg != '0)) begin
            if (rem_reg == '0) begin
                fin_valid_next = 1'b1;
                fin_id_next    = ID_W'(head_idx_reg) + ID_W'(1);
                head_next      = head_reg + IDX_W'(1);
                fill_next      = fill_reg - CNT_W'(1);
                completed_next = completed_reg + CNT_W'(1);
            end else begin
                rem_next = rem_reg - TIME_W'(1);
            end
        end

        if (cmd.head_fetch) begin
            head_idx_next = fifo_rdata_reg;
        end

        if (cmd.head_load) begin
            rem_next = bur_rdata_reg;
        end

        // Arrival scan: one table read issued and one compare done per cycle.
        if (cmd.scan) begin
            if (scan_cnt_reg != loaded_reg) begin
                chk_valid_next = 1'b1;
                chk_idx_next   = scan_cnt_reg[IDX_W-1:0];
                scan_cnt_next  = scan_cnt_reg + CNT_W'(1);
            end else begin
                chk_valid_next = 1'b0;
            end
            if (push) begin
                tail_next = tail_reg + IDX_W'(1);
                fill_next = fill_reg + CNT_W'(1);
                if (fill_reg == '0) begin
                    head_idx_next = chk_idx_reg;
                    rem_next      = bur_rdata_reg;
                end
            end
        end

        if (cmd.finish) begin
            if (op_tick_reg && (tick_reg != TICK_MAX)) begin
                tick_next = tick_reg + TICK_W'(1);
            end
            m_valid_next     = 1'b1;
            m_running_next   = (fill_reg != '0) ? (ID_W'(head_idx_reg) + ID_W'(1)) : '0;
            m_fin_valid_next = fin_valid_reg;
            m_fin_id_next    = fin_id_reg;
            m_tick_next      = tick_next;
            m_all_done_next  = (completed_reg == loaded_reg);
            m_rejected_next  = rejected_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            rem_reg       <= '0;
            loaded_reg    <= '0;
            completed_reg <= '0;
            tick_reg      <= '0;
            scan_cnt_reg  <= '0;
            chk_valid_reg <= 1'b0;
            op_tick_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            loaded_reg    <= loaded_next;
            completed_reg <= completed_next;
            tick_reg      <= tick_next;
            scan_cnt_reg  <= scan_cnt_next;
            chk_valid_reg <= chk_valid_next;
            op_tick_reg   <= op_tick_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg     <= chk_idx_next;
        head_idx_reg    <= head_idx_next;
        fin_valid_reg   <= fin_valid_next;
        fin_id_reg      <= fin_id_next;
        rejected_reg    <= rejected_next;
        m_running_reg   <= m_running_next;
        m_fin_valid_reg <= m_fin_valid_next;
        m_fin_id_reg    <= m_fin_id_next;
        m_tick_reg      <= m_tick_next;
        m_all_done_reg  <= m_all_done_next;
        m_rejected_reg  <= m_rejected_next;
    end

    always_comb begin
        status.pop_refill = (fill_reg > CNT_W'(1)) && (rem_reg == '0);
        status.scan_done  = (scan_cnt_reg == loaded_reg) && !chk_valid_reg;
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid          = m_valid_reg;
    assign m_running_id     = m_running_reg;
    assign m_finished_valid = m_fin_valid_reg;
    assign m_finished_id    = m_fin_id_reg;
    assign m_tick_now       = m_tick_reg;
    assign m_all_done       = m_all_done_reg;
    assign m_load_rejected  = m_rejected_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_PROCS))
        else $error("ready FIFO fill exceeds the table depth");

    a_completed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        completed_reg <= loaded_reg)
        else $error("more processes completed than were loaded");

    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_fin_valid_reg && m_rejected_reg))
        else $error("result flags both a completion and a rejected load");

    a_tick_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && op_tick_reg) |=> (m_valid_reg && (m_tick_reg != '0)))
        else $error("tick transaction did not advance the tick counter");

endmodule

### hdl/fcfs_tick_scheduler.sv
// Top level of the first-come-first-served tick scheduler.
// Depends on fcfs_pkg, fcfs_ctrl and fcfs_dpath.
//
// Usage: every input transaction on the s_ channel is either a load (opcode 0),
// which stores one process's arrival tick and burst length in the next free
// table slot, or a tick (opcode 1), which advances simulated time by one.
// Each input transaction yields exactly one result transaction on the m_
// channel: the process at the head of the ready queue, the process that
// finished in this tick if any, the tick counter, an all-done flag and a
// flag for a load that found the table full.
// Sequence: a load goes straight to the final state after acceptance. A tick
// first pops, then walks the loaded arrival entries one per cycle through the
// table memory; when a process retires and another takes the head, a head
// fetch and a head load step come before the walk (its burst is fetched from
// the table). The next transaction is accepted only once a result is
// registered; one transaction is in progress at a time.
// The result register lets the next transaction be accepted while the last
// result still waits; if the receiver stalls longer, the block holds in its
// final state until the result register frees up.
// Reset (aresetn, synchronous, active low) empties the queue and clears the
// counters; table contents need no clearing, since only loaded entries are read.
module fcfs_tick_scheduler
    import fcfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    input  logic [TIME_W-1:0] s_arrival_time,
    input  logic [TIME_W-1:0] s_burst_time,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ID_W-1:0]   m_running_id,
    output logic              m_finished_valid,
    output logic [ID_W-1:0]   m_finished_id,
    output logic [TICK_W-1:0] m_tick_now,
    output logic              m_all_done,
    output logic              m_load_rejected
);

    fcfs_cmd_t    cmd;
    fcfs_status_t status;

    // The controller decides which step of a tick runs in each cycle.
    fcfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds all tables, queue pointers, counters and the result register.
    fcfs_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_arrival_time   (s_arrival_time),
        .s_burst_time     (s_burst_time),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_running_id     (m_running_id),
        .m_finished_valid (m_finished_valid),
        .m_finished_id    (m_finished_id),
        .m_tick_now       (m_tick_now),
        .m_all_done       (m_all_done),
        .m_load_rejected  (m_load_rejected)
    );

endmodule

### tb/tb_fcfs_tick_scheduler.sv
`timescale 1ns / 100ps
// Self-checking testbench for fcfs_tick_scheduler: random load/tick traffic with random idling
// on both channels, checked against a cycle-free scheduling predictor. Depends on fcfs_pkg.

typedef logic [fcfs_pkg::TIME_W-1:0] time_val_t;
typedef logic [fcfs_pkg::ID_W-1:0]   proc_id_t;
typedef logic [fcfs_pkg::IDX_W-1:0]  proc_idx_t;

typedef struct packed {
    proc_id_t                    running_id;
    logic                        finished_valid;
    proc_id_t                    finished_id;
    logic [fcfs_pkg::TICK_W-1:0] tick_now;
    logic                        all_done;
    logic                        load_rejected;
} step_result_t;

// Keeps its own copy of the process table and ready queue, predicts one result per
// accepted transaction and checks the results in order.
class step_scoreboard;
    time_val_t                   arrival_tbl [fcfs_pkg::MAX_PROCS];
    time_val_t                   burst_tbl   [fcfs_pkg::MAX_PROCS];
    proc_idx_t                   ready_q [$];
    time_val_t                   head_left;
    int unsigned                 loaded_n;
    int unsigned                 done_n;
    logic [fcfs_pkg::TICK_W-1:0] tick_ctr;
    step_result_t                expected_steps [$];
    int unsigned                 fails;

    function new();
        head_left = '0;
        loaded_n  = 0;
        done_n    = 0;
        tick_ctr  = '0;
        fails     = 0;
    endfunction

    function void apply_item(logic op, time_val_t arr, time_val_t bur);
        step_result_t r;
        r = '0;
        if (op == fcfs_pkg::OP_LOAD) begin
            if (loaded_n >= fcfs_pkg::MAX_PROCS) begin
                r.load_rejected = 1'b1;
            end else begin
                arrival_tbl[loaded_n] = arr;
                burst_tbl[loaded_n]   = bur;
                loaded_n++;
            end
        end else begin
            if (ready_q.size() != 0) begin
                if (head_left == '0) begin
                    r.finished_valid = 1'b1;
                    r.finished_id    = proc_id_t'(ready_q[0]) + proc_id_t'(1);
                    void'(ready_q.pop_front());
                    done_n++;
                    if (ready_q.size() != 0) head_left = burst_tbl[ready_q[0]];
                end else begin
                    head_left--;
                end
            end
            for (int i = 0; i < loaded_n; i++) begin
                if ({1'b0, arrival_tbl[i]} == tick_ctr && ready_q.size() < fcfs_pkg::MAX_PROCS) begin
                    if (ready_q.size() == 0) head_left = burst_tbl[i];
                    ready_q.push_back(proc_idx_t'(i));
                end
            end
            if (tick_ctr != fcfs_pkg::TICK_MAX) tick_ctr++;
        end
        r.running_id = (ready_q.size() != 0) ? proc_id_t'(ready_q[0]) + proc_id_t'(1) : '0;
        r.tick_now   = tick_ctr;
        r.all_done   = (done_n == loaded_n);
        expected_steps.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: step check %s expected %0d actual %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    function void check_step(step_result_t got);
        step_result_t want;
        if (expected_steps.size() == 0) begin
            $display("%0t: step check result with nothing outstanding, tick_now actual %0d",
                     $time, got.tick_now);
            fails++;
            return;
        end
        want = expected_steps.pop_front();
        compare_field("running_id", want.running_id, got.running_id);
        compare_field("finished_valid", want.finished_valid, got.finished_valid);
        compare_field("finished_id", want.finished_id, got.finished_id);
        compare_field("tick_now", want.tick_now, got.tick_now);
        compare_field("all_done", want.all_done, got.all_done);
        compare_field("load_rejected", want.load_rejected, got.load_rejected);
    endfunction
endclass

module tb_fcfs_tick_scheduler;
    import fcfs_pkg::*;

    // The slowest legal run is roughly 1100 transactions, each with the longest tick,
    // the longest sender gap and the longest receiver stall; this is several
    // times that.
    localparam int unsigned RUN_LIMIT    = 600000;
    localparam int          RANDOM_ITEMS = 1050;
    // By this point of the random part the table is topped up and then only
    // rejected loads and ticks follow.
    localparam int          FILL_AT      = 700;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_opcode;
    logic [TIME_W-1:0] s_arrival_time;
    logic [TIME_W-1:0] s_burst_time;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [ID_W-1:0]   m_running_id;
    logic              m_finished_valid;
    logic [ID_W-1:0]   m_finished_id;
    logic [TICK_W-1:0] m_tick_now;
    logic              m_all_done;
    logic              m_load_rejected;

    // When calm is set, neither side idles, so long back-to-back stretches occur.
    bit                calm = 1'b0;
    int unsigned       stall_left = 0;
    int unsigned       cycle_count = 0;
    step_result_t      seen;
    step_scoreboard    sb;

    fcfs_tick_scheduler u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_arrival_time   (s_arrival_time),
        .s_burst_time     (s_burst_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_running_id     (m_running_id),
        .m_finished_valid (m_finished_valid),
        .m_finished_id    (m_finished_id),
        .m_tick_now       (m_tick_now),
        .m_all_done       (m_all_done),
        .m_load_rejected  (m_load_rejected)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Idle lengths are mostly short, now and then a long pause.
    function automatic int unsigned idle_length();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls of m_ready; none start while calm is set.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left <= idle_length() - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every result transaction is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready) begin
            seen.running_id     = m_running_id;
            seen.finished_valid = m_finished_valid;
            seen.finished_id    = m_finished_id;
            seen.tick_now       = m_tick_now;
            seen.all_done       = m_all_done;
            seen.load_rejected  = m_load_rejected;
            sb.check_step(seen);
        end
    end

    // Presents one transaction and holds it until the block takes it; the
    // prediction is made at the accepting edge. Valid is left high so that a
    // following transaction can go out back to back.
    task automatic send_item(logic op, time_val_t arr, time_val_t bur);
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_arrival_time <= arr;
        s_burst_time   <= bur;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.apply_item(op, arr, bur);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, time_val_t'($urandom), time_val_t'($urandom));
    endtask

    // Random gap in front of the next transaction; valid drops only if the gap is real.
    task automatic idle_before();
        int unsigned n;
        n = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if (n != 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Holds the sender off until every outstanding result has been received.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_steps.size() != 0);
    endtask

    // Run timeout.
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("fcfs_tick_scheduler: mismatch");
        $finish;
    end

    initial begin
        int unsigned group_n;
        time_val_t   arr;
        time_val_t   bur;

        sb = new();
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_opcode       <= OP_LOAD;
        s_arrival_time <= '0;
        s_burst_time   <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. A tick with nothing loaded counts as all done and leaves
        // the queue empty; it moves time to 1.
        send_tick();
        // Two processes arriving on the same tick are queued in load order. The
        // first has a zero burst, so it holds the head for exactly one tick.
        send_item(OP_LOAD, time_val_t'(1), time_val_t'(0));
        send_item(OP_LOAD, time_val_t'(1), time_val_t'(2));
        // Arrivals while another process runs, then a handover to a new head
        // whose burst comes from the table.
        send_item(OP_LOAD, time_val_t'(3), time_val_t'(0));
        send_item(OP_LOAD, time_val_t'(3), time_val_t'(1));
        send_item(OP_LOAD, time_val_t'(4), time_val_t'(0));
        // Enough ticks to run everything out and idle on an empty queue.
        repeat (12) send_tick();

        // The sender pauses until every result of the directed part is in.
        wait_all_results();

        // Random part. Processes are loaded in small groups that arrive a little
        // ahead of the current tick with short bursts, so the queue fills and drains
        // many times. One slot stays free until the table is topped up late in the run.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 128 == 0) calm = ($urandom_range(0, 9) < 3);
            if ($urandom_range(0, 99) == 0) wait_all_results();
            idle_before();
            if (k == FILL_AT) begin
                // Largest arrival and burst: never reached, so at least one process stays
                // unfinished and all_done stays low from here on.
                while (sb.loaded_n < MAX_PROCS) send_item(OP_LOAD, '1, '1);
                // Table full: both field extremes are ignored.
                send_item(OP_LOAD, '0, '0);
                send_item(OP_LOAD, '1, '1);
            end else if (sb.loaded_n >= MAX_PROCS && $urandom_range(0, 9) < 3) begin
                send_item(OP_LOAD, time_val_t'($urandom), time_val_t'($urandom));
            end else if (sb.loaded_n < MAX_PROCS - 1 && $urandom_range(0, 199) < 3) begin
                group_n = $urandom_range(1, 3);
                while (group_n != 0 && sb.loaded_n < MAX_PROCS - 1) begin
                    arr = time_val_t'(sb.tick_ctr) + time_val_t'($urandom_range(0, 50));
                    bur = ($urandom_range(0, 99) < 85) ? time_val_t'($urandom_range(0, 5))
                                                      : time_val_t'($urandom_range(6, 40));
                    send_item(OP_LOAD, arr, bur);
                    group_n--;
                end
            end else begin
                send_tick();
            end
        end

        // Drain, then give the block time to show any stray result.
        wait_all_results();
        repeat (40) @(posedge aclk);
        if (sb.fails == 0 && sb.expected_steps.size() == 0) begin
            $display("fcfs_tick_scheduler: match");
        end else begin
            $display("fcfs_tick_scheduler: mismatch");
        end
        $finish;
    end

endmodule
